### src/dbd_pkg.sv
// Package: widths, reciprocal constants and the month offset table for days_between_dates.
package dbd_pkg;

    localparam int YearW  = 14;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int NumW   = 23;
    localparam int CountW = 22;
    localparam int InW    = 48;
    localparam int OutW   = 24;

    localparam int Recip25   = 5243;
    localparam int RecipSh   = 17;
    localparam int MonthFeb  = 2;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctrl;

    function automatic logic [8:0] f_days_before(input logic [MonthW-1:0] month);
        logic [8:0] v;
        unique case (month) inside
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            default:    v = 9'd334;
        endcase
        return v;
    endfunction

endpackage

### src/dbd_day_num.sv
// Three-stage pipeline that maps one date to its day number.
module dbd_day_num
    import dbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [YearW-1:0]  i_year,
    input  logic [MonthW-1:0] i_month,
    input  logic [DayW-1:0]   i_day,
    output logic [NumW-1:0]   o_num
);

    // stage 1
    logic [NumW-1:0] r_y365, n_y365;
    logic [12:0]     r_q4, n_q4;
    logic [25:0]     r_p100, n_p100;
    logic [23:0]     r_p400, n_p400;
    logic [24:0]     r_m4, n_m4;
    logic [23:0]     r_m16, n_m16;
    logic [YearW-1:0] r_year;
    logic [8:0]      r_mtab, n_mtab;
    logic            r_late, n_late;
    logic [DayW-1:0] r_day;

    // stage 2
    logic [NumW-1:0] r_s1, n_s1;
    logic [12:0]     r_t, n_t;
    logic            r_leap, n_leap;

    // stage 3
    logic [NumW-1:0] r_num, n_num;

    logic [YearW:0] w_y99, w_y399, w_y3;
    logic [8:0]     w_c100;
    logic [6:0]     w_c400;
    logic [7:0]     w_q100;
    logic [6:0]     w_q400;
    logic [11:0]    w_q100x;
    logic [10:0]    w_q400x;
    logic           w_div4, w_div100, w_div400;

    always_comb begin
        w_y3   = {1'b0, i_year} + 15'd3;
        w_y99  = {1'b0, i_year} + 15'd99;
        w_y399 = {1'b0, i_year} + 15'd399;
        n_y365 = NumW'(i_year) * NumW'(365);
        n_q4   = w_y3[14:2];
        n_p100 = 26'(w_y99[14:2]) * 26'(Recip25);
        n_p400 = 24'(w_y399[14:4]) * 24'(Recip25);
        n_m4   = 25'(i_year[13:2]) * 25'(Recip25);
        n_m16  = 24'(i_year[13:4]) * 24'(Recip25);
        n_mtab = f_days_before(i_month);
        n_late = (i_month > 4'(MonthFeb));
    end

    always_comb begin
        w_c100   = r_p100[25:RecipSh];
        w_c400   = r_p400[23:RecipSh];
        w_q100   = r_m4[24:RecipSh];
        w_q400   = r_m16[23:RecipSh];
        w_q100x  = 12'(w_q100) * 12'd25;
        w_q400x  = 11'(w_q400) * 11'd25;
        w_div4   = (r_year[1:0] == 2'd0);
        w_div100 = w_div4 && (w_q100x == r_year[13:2]);
        w_div400 = (r_year[3:0] == 4'd0) && (w_q400x == {1'b0, r_year[13:4]});
        n_leap   = r_late && (w_div400 || (w_div4 && !w_div100));
        n_s1     = r_y365 + NumW'(r_mtab) + NumW'(r_day);
        n_t      = r_q4 + 13'(w_c400) - 13'(w_c100);
    end

    assign n_num = r_s1 + NumW'(r_t) + NumW'(r_leap);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y365 <= n_y365;
            r_q4   <= n_q4;
            r_p100 <= n_p100;
            r_p400 <= n_p400;
            r_m4   <= n_m4;
            r_m16  <= n_m16;
            r_year <= i_year;
            r_mtab <= n_mtab;
            r_late <= n_late;
            r_day  <= i_day;
            r_s1   <= n_s1;
            r_t    <= n_t;
            r_leap <= n_leap;
            r_num  <= n_num;
        end
    end

    assign o_num = r_num;

endmodule

### src/dbd_absdiff.sv
// Output stage: absolute difference of two day numbers into the result register.
module dbd_absdiff
    import dbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctrl        i_ctrl,
    input  logic [NumW-1:0]   i_num_a,
    input  logic [NumW-1:0]   i_num_b,
    output logic              o_vld,
    output logic [CountW-1:0] o_count
);

    logic              r_vld;
    logic [CountW-1:0] r_count, n_count;
    logic [NumW-1:0]   w_diff;

    always_comb begin
        if (i_num_a >= i_num_b) begin
            w_diff = i_num_a - i_num_b;
        end else begin
            w_diff = i_num_b - i_num_a;
        end
        n_count = w_diff[CountW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.en) begin
            r_vld <= i_ctrl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_count <= n_count;
        end
    end

    assign o_vld   = r_vld;
    assign o_count = r_count;

endmodule

### src/days_between_dates.sv
// Top level of days_between_dates: absolute day count between two Gregorian dates.
// Data pass three day-number stages, then the difference register driving o_m_tdata.
// Throughput: one transfer per cycle while the output is not stalled.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset: synchronous, active low; clears the valid bits, data registers keep their contents.
module days_between_dates
    import dbd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    // first_year, first_month, first_day, second_year, second_month, second_day, zero pad
    input  logic [InW-1:0]  i_s_tdata,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    // day_count, zero pad
    output logic [OutW-1:0] o_m_tdata
);

    logic              w_en;
    logic [2:0]        r_vld;
    logic [NumW-1:0]   w_num_a, w_num_b;
    logic [CountW-1:0] w_count;
    t_pipe_ctrl        w_ctrl;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[1:0], i_s_tvalid};
        end
    end

    dbd_day_num u_first (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_s_tdata[13:0]),
        .i_month (i_s_tdata[17:14]),
        .i_day   (i_s_tdata[22:18]),
        .o_num   (w_num_a)
    );

    dbd_day_num u_second (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_s_tdata[36:23]),
        .i_month (i_s_tdata[40:37]),
        .i_day   (i_s_tdata[45:41]),
        .o_num   (w_num_b)
    );

    assign w_ctrl.en  = w_en;
    assign w_ctrl.vld = r_vld[2];

    dbd_absdiff u_absdiff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_num_a (w_num_a),
        .i_num_b (w_num_b),
        .o_vld   (o_m_tvalid),
        .o_count (w_count)
    );

    assign o_m_tdata = {{(OutW-CountW){1'b0}}, w_count};

endmodule

### src/dbd_checker.sv
// Port checker for days_between_dates and its bind.
module dbd_checker
    import dbd_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_s_tready,
    input logic            o_m_tvalid,
    input logic            i_m_tready,
    input logic [OutW-1:0] o_m_tdata
);

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output transfer changed while stalled");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output stalled");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OutW-1:CountW] == '0)
        else $error("pad bits of output set");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/sv/day_count_checker.sv
// Checker for days_between_dates: watches both streams, predicts each day count and compares.
`timescale 1ns / 100ps
module day_count_checker
    import dbd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    input  logic [InW-1:0]  i_s_tdata,
    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    input  logic [OutW-1:0] i_m_tdata,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    localparam int MonthJan = 1;
    localparam int MonthDec = 12;
    localparam int unsigned MonthStart [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    logic [CountW-1:0] day_count_due [$];
    int fail_count = 0;
    int checked    = 0;
    int pending    = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_pending    = pending;

    function automatic bit leap_year(input int unsigned y);
        if (y % 400 == 0) begin
            return 1'b1;
        end
        if (y % 100 == 0) begin
            return 1'b0;
        end
        return (y % 4 == 0);
    endfunction

    // days since a fixed origin; year 0 counts as a leap year
    function automatic int unsigned day_index(input logic [YearW-1:0] year,
                                              input logic [MonthW-1:0] month,
                                              input logic [DayW-1:0] day);
        int unsigned y;
        int unsigned m;
        int unsigned n;
        y = year;
        m = month;
        if (m < MonthJan) begin
            m = MonthJan;
        end
        if (m > MonthDec) begin
            m = MonthDec;
        end
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        n += MonthStart[m - 1];
        if (m > MonthFeb && leap_year(y)) begin
            n += 1;
        end
        n += day;
        return n;
    endfunction

    function automatic logic [CountW-1:0] days_apart(input logic [InW-1:0] pair);
        int unsigned a;
        int unsigned b;
        int unsigned gap;
        a = day_index(pair[13:0], pair[17:14], pair[22:18]);
        b = day_index(pair[36:23], pair[40:37], pair[45:41]);
        gap = (a >= b) ? a - b : b - a;
        return gap[CountW-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [CountW-1:0] want;
        logic [CountW-1:0] got;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[CountW-1:0];
                if (day_count_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: day count %0d arrived with none expected", $time, got);
                    end
                    fail_count++;
                end else begin
                    want = day_count_due.pop_front();
                    checked++;
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("%0t: day count mismatch, expected %0d, got %0d",
                                     $time, want, got);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                day_count_due.push_back(days_apart(i_s_tdata));
            end
        end
        pending <= day_count_due.size();
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for days_between_dates: clock, reset, date-pair stimulus, output pacing, verdict.
`timescale 1ns / 100ps
module tb_top;
    import dbd_pkg::*;

    localparam int RandomItems = 1650;
    localparam int HoldCycles  = 200;
    localparam int MaxYear     = 9999;
    localparam int MonthJan    = 1;
    localparam int MonthDec    = 12;
    localparam int MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [InW-1:0]  s_tdata;    // first_year, first_month, first_day, second_year, ...
    logic            m_tvalid;
    logic            m_tready;
    logic [OutW-1:0] m_tdata;    // day_count, zero pad

    logic quiet    = 1'b0;
    logic hold_req = 1'b0;
    bit   hold_taken;
    int   sent;
    int   directed;
    int   fail_count;
    int   pending;
    int   checked;

    always #4 i_clk = ~i_clk;

    days_between_dates dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    day_count_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    task automatic send_pair(input logic [YearW-1:0] y1, input logic [MonthW-1:0] m1,
                             input logic [DayW-1:0] d1, input logic [YearW-1:0] y2,
                             input logic [MonthW-1:0] m2, input logic [DayW-1:0] d2);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, d2, m2, y2, d1, m1, y1};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic valid_date(output logic [YearW-1:0] y, output logic [MonthW-1:0] m,
                              output logic [DayW-1:0] d, input int y_lo, input int y_hi);
        int last;
        y = YearW'($urandom_range(y_lo, y_hi));
        m = MonthW'($urandom_range(MonthJan, MonthDec));
        last = MonthLen[m - 1];
        if (m == MonthFeb && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) begin
            last++;
        end
        d = DayW'($urandom_range(1, last));
    endtask

    initial begin : source
        logic [YearW-1:0]  y1;
        logic [YearW-1:0]  y2;
        logic [MonthW-1:0] m1;
        logic [MonthW-1:0] m2;
        logic [DayW-1:0]   d1;
        logic [DayW-1:0]   d2;
        int kind;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(2024, 5, 17, 2024, 5, 17);
        send_pair(1, 1, 1, YearW'(MaxYear), 12, 31);
        send_pair(YearW'(MaxYear), 12, 31, 1, 1, 1);
        send_pair(2000, 2, 29, 2000, 3, 1);
        send_pair(1900, 2, 28, 1900, 3, 1);
        send_pair(2100, 3, 1, 2096, 3, 1);
        send_pair(1600, 12, 31, 1601, 1, 1);
        send_pair(2023, 0, 10, 2023, 1, 10);
        send_pair(2023, 13, 5, 2023, 12, 5);
        send_pair(2024, 15, 31, 2024, 12, 31);
        send_pair(2023, 4, 0, 2023, 3, 31);
        send_pair(2023, 2, 31, 2023, 3, 3);
        send_pair(0, 3, 1, 0, 2, 28);
        send_pair(0, 1, 1, 1, 1, 1);
        send_pair(16383, 15, 31, 0, 0, 0);
        send_pair(0, 0, 0, 16383, 15, 31);
        send_pair(10000, 1, 1, YearW'(MaxYear), 12, 31);
        send_pair(16383, 12, 31, 5000, 6, 15);
        send_pair('0, '0, '0, '0, '0, '0);
        send_pair('1, '1, '1, '1, '1, '1);
        send_pair(10922, 10, 21, 5461, 5, 10);
        directed = sent;

        // drain before the random part
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int i = 0; i < RandomItems; i++) begin
            if (i == 400) begin
                hold_req <= 1'b1;
            end
            if (i == 900) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (i == 1100) begin
                quiet <= 1'b1;
            end
            if (i == 1300) begin
                quiet <= 1'b0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                valid_date(y1, m1, d1, 1, MaxYear);
                if (kind < 30) begin
                    valid_date(y2, m2, d2, (y1 > 2) ? y1 - 2 : 1,
                               (y1 < MaxYear - 2) ? y1 + 2 : MaxYear);
                end else begin
                    valid_date(y2, m2, d2, 1, MaxYear);
                end
            end else begin
                y1 = YearW'($urandom);
                m1 = MonthW'($urandom);
                d1 = DayW'($urandom);
                y2 = YearW'($urandom);
                m2 = MonthW'($urandom);
                d2 = DayW'($urandom);
            end
            send_pair(y1, m1, d1, y2, m2, d2);
        end
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Summary: %0d date pairs sent (%0d directed), %0d day counts compared.",
                 sent, directed, checked);
        $display({"Covered out-of-range months and days, year 0, 14-bit years with wrap, ",
                  "and a long output hold-off."});
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : sink
        int stall;
        m_tready   <= 1'b0;
        hold_taken = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### days_between_dates.f
src/dbd_pkg.sv
src/dbd_day_num.sv
src/dbd_absdiff.sv
src/days_between_dates.sv
src/dbd_checker.sv
tb/sv/day_count_checker.sv
tb/sv/tb_top.sv
